### rtl/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types, character codes and helpers for the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    localparam int VALUE_W    = 32;
    localparam int FIELD_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int DIG_IDX_W  = 4;

    typedef enum logic [1:0] {
        CONV_SDEC = 2'd0,
        CONV_UDEC = 2'd1,
        CONV_LHEX = 2'd2,
        CONV_UHEX = 2'd3
    } conv_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef struct packed {
        conv_t                req_type;
        logic [VALUE_W-1:0]   value;
        logic [FIELD_W-1:0]   field_width;
        logic [FIELD_W-1:0]   precision;
        logic                 has_precision;
        logic                 left_align;
        logic                 zero_fill;
    } req_t;

    typedef struct packed {
        logic [7:0]           out_char;
        logic                 char_valid;
        logic                 last_char;
        logic [COUNT_W-1:0]   total_count;
    } result_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10)
            return CH_ZERO + {4'b0, d};
        else
            return base + {4'b0, d} - 8'd10;
    endfunction

endpackage

### rtl/ifmt_b2d.sv
// ----------------------------------------------------------------------------
// ifmt_b2d
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Hex loads pass the magnitude straight through as nibbles.
// ----------------------------------------------------------------------------
module ifmt_b2d
    import ifmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               hex,
    input  logic [VALUE_W-1:0] mag,
    output logic               done,
    output logic [BCD_W-1:0]   digits
);

    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

    logic               run_reg,   run_next;
    logic               done_reg,  done_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg,   bcd_next;
    logic [BCD_W-1:0]   adj;

    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (load)
        begin
            shift_next = mag;
            cnt_next   = '0;
            if (hex)
            begin
                bcd_next  = {(BCD_W-VALUE_W)'(0), mag};
                done_next = 1'b1;
                run_next  = 1'b0;
            end
            else
            begin
                bcd_next = '0;
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            bcd_next   = {adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

### rtl/integer_field_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_field_formatter_top
// printf-style integer conversion: one value in, a padded character field out.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req and raise start; the transfer happens on an edge where
//   start is high and busy is low. busy then stays high until the last
//   character has been launched.
//   Results: one character per cycle on result, marked by result_valid. The
//   last one has last_char set and total_count holding the field length. An
//   empty field gives a single result with char_valid low.
//   Sequence: decimal conversion runs in the bit-serial BCD converter, which
//   shifts in every magnitude bit and then signals done (hex loads directly),
//   then come the sizing states ST_COUNT, ST_SIZE, ST_PAD and ST_BOUND, and
//   then the field leaves at one character per cycle. A field gives 1..64 results.
//   The receiver has no back-pressure; results must be taken as they come.
//   Reset clears the sequencer and the strobe; no transfer is in flight.
// ----------------------------------------------------------------------------
module integer_field_formatter_top
    import ifmt_pkg::*;
#(
    parameter int MAX_FIELD = 63
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  req_t    req,
    output logic    busy,
    output logic    result_valid,
    output result_t result
);

    localparam logic [7:0] MAX_F = 8'(MAX_FIELD);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_SIZE,
        ST_PAD,
        ST_BOUND,
        ST_EMIT
    } state_t;

    state_t               state_reg,     state_next;
    logic                 upper_reg,     upper_next;
    logic                 neg_reg,       neg_next;
    logic [FIELD_W-1:0]   width_reg,     width_next;
    logic [FIELD_W-1:0]   prec_reg,      prec_next;
    logic                 has_prec_reg,  has_prec_next;
    logic                 left_reg,      left_next;
    logic                 zfill_reg,     zfill_next;
    logic [DIG_IDX_W-1:0] nd_reg,        nd_next;
    logic [FIELD_W-1:0]   zeros_reg,     zeros_next;
    logic [COUNT_W-1:0]   body_reg,      body_next;
    logic [FIELD_W-1:0]   pad_reg,       pad_next;
    logic [COUNT_W-1:0]   total_reg,     total_next;
    logic [FIELD_W-1:0]   pre_reg,       pre_next;
    logic [COUNT_W-1:0]   e_zero_reg,    e_zero_next;
    logic [COUNT_W-1:0]   e_dig_reg,     e_dig_next;
    logic [COUNT_W-1:0]   e_post_reg,    e_post_next;
    logic [COUNT_W-1:0]   idx_reg,       idx_next;
    logic [DIG_IDX_W-1:0] dig_idx_reg,   dig_idx_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              result_reg,    result_next;

    logic                 accept;
    logic                 neg_in;
    logic [VALUE_W-1:0]   mag_in;
    logic                 conv_done;
    logic [BCD_W-1:0]     digits;
    logic [DIG_IDX_W-1:0] hi;
    logic                 is_last;
    logic [DIGIT_W-1:0]   cur_digit;

    assign accept = start && (state_reg == ST_IDLE);
    assign neg_in = (req.req_type == CONV_SDEC) && req.value[VALUE_W-1];
    assign mag_in = neg_in ? (~req.value + 1'b1) : req.value;

    ifmt_b2d u_b2d (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .hex    (req.req_type == CONV_LHEX || req.req_type == CONV_UHEX),
        .mag    (mag_in),
        .done   (conv_done),
        .digits (digits)
    );

    always_comb
    begin
        hi = '0;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (digits[k*DIGIT_W +: DIGIT_W] != '0)
                hi = DIG_IDX_W'(k + 1);
        end
    end

    assign is_last   = (idx_reg == total_reg - 1'b1);
    assign cur_digit = digits[{dig_idx_reg, 2'b00} +: DIGIT_W];

    always_comb
    begin
        state_next     = state_reg;
        upper_next     = upper_reg;
        neg_next       = neg_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        has_prec_next  = has_prec_reg;
        left_next      = left_reg;
        zfill_next     = zfill_reg;
        nd_next        = nd_reg;
        zeros_next     = zeros_reg;
        body_next      = body_reg;
        pad_next       = pad_reg;
        total_next     = total_reg;
        pre_next       = pre_reg;
        e_zero_next    = e_zero_reg;
        e_dig_next     = e_dig_reg;
        e_post_next    = e_post_reg;
        idx_next       = idx_reg;
        dig_idx_next   = dig_idx_reg;
        res_valid_next = 1'b0;
        result_next    = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    upper_next    = (req.req_type == CONV_UHEX);
                    neg_next      = neg_in;
                    width_next    = ({2'b0, req.field_width} > MAX_F) ?
                                    MAX_F[FIELD_W-1:0] : req.field_width;
                    prec_next     = ({2'b0, req.precision} > MAX_F) ?
                                    MAX_F[FIELD_W-1:0] : req.precision;
                    has_prec_next = req.has_precision;
                    left_next     = req.left_align;
                    zfill_next    = req.zero_fill && !req.has_precision && !req.left_align;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                if (has_prec_reg && (prec_reg == '0) && (digits == '0))
                    nd_next = '0;
                else if (hi == '0)
                    nd_next = DIG_IDX_W'(1);
                else
                    nd_next = hi;
                state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                if (has_prec_reg && (prec_reg > {2'b0, nd_reg}))
                    zeros_next = prec_reg - {2'b0, nd_reg};
                else
                    zeros_next = '0;
                body_next  = {6'b0, neg_reg} + {1'b0, zeros_next} + {3'b0, nd_reg};
                state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if ({1'b0, width_reg} > body_reg)
                begin
                    pad_next   = FIELD_W'({1'b0, width_reg} - body_reg);
                    total_next = {1'b0, width_reg};
                end
                else
                begin
                    pad_next   = '0;
                    total_next = body_reg;
                end
                state_next = ST_BOUND;
            end
            ST_BOUND:
            begin
                pre_next     = (!left_reg && !zfill_reg) ? pad_reg : '0;
                e_zero_next  = {1'b0, pre_next} + {6'b0, neg_reg};
                e_post_next  = left_reg ? body_reg : total_reg;
                e_dig_next   = e_post_next - {3'b0, nd_reg};
                dig_idx_next = nd_reg - 1'b1;
                idx_next     = '0;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                res_valid_next = 1'b1;
                if (total_reg == '0)
                begin
                    result_next.out_char    = CH_NONE;
                    result_next.char_valid  = 1'b0;
                    result_next.last_char   = 1'b1;
                    result_next.total_count = '0;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    if (idx_reg < {1'b0, pre_reg})
                        result_next.out_char = CH_SPACE;
                    else if (idx_reg < e_zero_reg)
                        result_next.out_char = CH_MINUS;
                    else if (idx_reg < e_dig_reg)
                        result_next.out_char = CH_ZERO;
                    else if (idx_reg < e_post_reg)
                    begin
                        result_next.out_char = digit_char(cur_digit, upper_reg);
                        dig_idx_next         = dig_idx_reg - 1'b1;
                    end
                    else
                        result_next.out_char = CH_SPACE;
                    result_next.char_valid  = 1'b1;
                    result_next.last_char   = is_last;
                    result_next.total_count = is_last ? total_reg : '0;
                    idx_next                = idx_reg + 1'b1;
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg    <= upper_next;
        neg_reg      <= neg_next;
        width_reg    <= width_next;
        prec_reg     <= prec_next;
        has_prec_reg <= has_prec_next;
        left_reg     <= left_next;
        zfill_reg    <= zfill_next;
        nd_reg       <= nd_next;
        zeros_reg    <= zeros_next;
        body_reg     <= body_next;
        pad_reg      <= pad_next;
        total_reg    <= total_next;
        pre_reg      <= pre_next;
        e_zero_reg   <= e_zero_next;
        e_dig_reg    <= e_dig_next;
        e_post_reg   <= e_post_next;
        idx_reg      <= idx_next;
        dig_idx_reg  <= dig_idx_next;
        result_reg   <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/ifmt_checker.sv
// ----------------------------------------------------------------------------
// ifmt_checker
// Port-level checks on the formatter's request and result transfers.
// ----------------------------------------------------------------------------
module ifmt_checker
    import ifmt_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    result_valid,
    input result_t result
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request transfer");

    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_char |-> busy)
        else $error("non-final result while idle");

    a_count_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_char |-> result.total_count == '0)
        else $error("count on non-final result");

    a_empty_field: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.char_valid |->
            result.last_char && result.total_count == '0 && result.out_char == CH_NONE)
        else $error("malformed empty-field result");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_char |=> !result_valid)
        else $error("result right after final result");

endmodule

bind integer_field_formatter_top ifmt_checker u_ifmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer field formatter. A queue of directed
// and random requests feeds a clocked driver with random start gaps; a
// clocked monitor compares every character strobe against a local model
// of the printf-style field and reports each mismatch.
// ----------------------------------------------------------------------------
module tb_top;
    import ifmt_pkg::*;

    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 120;
    localparam int QUIET_FIRST  = 120;
    localparam int QUIET_LAST   = 200;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    req_t    req = '0;
    logic    busy;
    logic    result_valid;
    result_t result;

    req_t    pending_reqs[$];
    bit      drain_before[$];
    result_t expected_chars[$];

    int      errors = 0;
    int      cycle_count = 0;
    int      reqs_sent = 0;
    int      chars_checked = 0;
    int      empty_fields = 0;
    int      directed_count = 0;
    int      conv_seen[4] = '{0, 0, 0, 0};

    integer_field_formatter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Expected field for one request, appended character by character.
    function automatic void predict_field(req_t r);
        logic [7:0]  digs[16];
        logic [7:0]  chars[$];
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] d;
        logic [7:0]  alpha;
        bit          neg;
        bit          zfill;
        int          nd;
        int          zeros;
        int          body;
        int          pad;
        int          width;
        int          prec;
        result_t     res;
        neg   = (r.req_type == CONV_SDEC) && r.value[31];
        mag   = neg ? (32'd0 - r.value) : r.value;
        base  = (r.req_type == CONV_LHEX || r.req_type == CONV_UHEX) ? 32'd16 : 32'd10;
        alpha = (r.req_type == CONV_UHEX) ? CH_UA : CH_LA;
        zfill = r.zero_fill && !r.has_precision && !r.left_align;
        width = (r.field_width > 63) ? 63 : int'(r.field_width);
        prec  = (r.precision > 63) ? 63 : int'(r.precision);
        nd    = 0;
        if (!(r.has_precision && prec == 0 && mag == 0))
        begin
            do
            begin
                d = mag % base;
                digs[nd] = (d < 10) ? (CH_ZERO + d[7:0]) : (alpha + d[7:0] - 8'd10);
                nd++;
                mag = mag / base;
            end while (mag != 0 && nd < 16);
        end
        zeros = (r.has_precision && prec > nd) ? prec - nd : 0;
        body  = (neg ? 1 : 0) + zeros + nd;
        pad   = (width > body) ? width - body : 0;
        if (!r.left_align && !zfill)
            repeat (pad) chars.push_back(CH_SPACE);
        if (neg)
            chars.push_back(CH_MINUS);
        if (zfill)
            repeat (pad) chars.push_back(CH_ZERO);
        repeat (zeros) chars.push_back(CH_ZERO);
        for (int i = nd; i > 0; i--)
            chars.push_back(digs[i - 1]);
        if (r.left_align)
            repeat (pad) chars.push_back(CH_SPACE);
        if (chars.size() == 0)
        begin
            res = '{out_char: CH_NONE, char_valid: 1'b0, last_char: 1'b1, total_count: '0};
            expected_chars.push_back(res);
            empty_fields++;
        end
        else
        begin
            foreach (chars[i])
            begin
                res.out_char    = chars[i];
                res.char_valid  = 1'b1;
                res.last_char   = (i == chars.size() - 1);
                res.total_count = res.last_char ? COUNT_W'(chars.size()) : '0;
                expected_chars.push_back(res);
            end
        end
    endfunction

    function automatic void queue_req(conv_t t, logic [31:0] v, int w, int p,
                                      bit hp, bit la, bit zf, bit drain);
        req_t r;
        r.req_type      = t;
        r.value         = v;
        r.field_width   = FIELD_W'(w);
        r.precision     = FIELD_W'(p);
        r.has_precision = hp;
        r.left_align    = la;
        r.zero_fill     = zf;
        pending_reqs.push_back(r);
        drain_before.push_back(drain);
    endfunction

    function automatic int random_size();
        case ($urandom_range(3))
            0: return 0;
            1: return $urandom_range(12, 1);
            2: return $urandom_range(63);
            default: return $urandom_range(30, 13);
        endcase
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return $urandom_range(20);
            1: return 32'd0 - $urandom_range(1000, 1);
            2:
            begin
                case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: directed corner cases, then random requests.
    initial
    begin
        queue_req(CONV_SDEC, 32'd0,          0,  0, 0, 0, 0, 0);
        queue_req(CONV_SDEC, 32'd0,          0,  0, 1, 0, 0, 0);
        queue_req(CONV_SDEC, 32'd0,          5,  0, 1, 0, 0, 0);
        queue_req(CONV_LHEX, 32'd0,          0,  0, 1, 1, 1, 0);
        queue_req(CONV_SDEC, 32'h8000_0000,  0,  0, 0, 0, 0, 0);
        queue_req(CONV_SDEC, 32'h7FFF_FFFF,  0,  0, 0, 0, 0, 0);
        queue_req(CONV_SDEC, 32'hFFFF_FFFF,  8,  0, 0, 0, 1, 0);
        queue_req(CONV_UDEC, 32'hFFFF_FFFF,  0,  0, 0, 0, 0, 0);
        queue_req(CONV_UDEC, 32'h8000_0000, 12,  0, 0, 1, 0, 0);
        queue_req(CONV_LHEX, 32'hDEAD_BEEF,  0,  0, 0, 0, 0, 0);
        queue_req(CONV_UHEX, 32'hDEAD_BEEF, 10,  0, 0, 0, 1, 0);
        queue_req(CONV_UHEX, 32'h0000_00AF,  0, 63, 1, 0, 0, 0);
        queue_req(CONV_SDEC, 32'hFFFF_FFF6,  0, 63, 1, 0, 0, 0);
        queue_req(CONV_SDEC, 32'd5,         63,  0, 0, 1, 0, 0);
        queue_req(CONV_SDEC, 32'hFFFF_FFFB, 63,  0, 0, 0, 1, 0);
        queue_req(CONV_UDEC, 32'd42,         0, 20, 0, 0, 0, 0);
        queue_req(CONV_SDEC, 32'd42,        10,  3, 1, 0, 1, 0);
        queue_req(CONV_SDEC, 32'hFFFF_FFD6, 10,  0, 0, 1, 1, 0);
        queue_req(CONV_SDEC, 32'hFFFF_FFD6, 12,  5, 1, 1, 0, 0);
        queue_req(CONV_LHEX, 32'h0000_0abc, 63, 63, 1, 1, 1, 0);
        queue_req(CONV_UDEC, 32'd0,         63, 63, 0, 0, 0, 0);
        directed_count = pending_reqs.size();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            queue_req(conv_t'($urandom_range(3)), random_value(), random_size(),
                      random_size(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), (i == 0) || (i == 300));
        end
    end

    // Driver: start goes high with the next request, holds while busy.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            bit quiet;
            bit ready;
            if (start && !busy)
            begin
                predict_field(req);
                conv_seen[req.req_type]++;
                reqs_sent++;
            end
            if (!(start && busy))
            begin
                quiet = (reqs_sent >= QUIET_FIRST) && (reqs_sent < QUIET_LAST);
                ready = (pending_reqs.size() > 0) &&
                        !(drain_before[0] && expected_chars.size() > 0) &&
                        (quiet || $urandom_range(99) >= 24);
                if (ready)
                begin
                    start <= 1'b1;
                    req   <= pending_reqs.pop_front();
                    void'(drain_before.pop_front());
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest expected character.
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && result_valid)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, result);
                errors++;
            end
            else
            begin
                exp_res = expected_chars.pop_front();
                chars_checked++;
                if (result.out_char !== exp_res.out_char)
                begin
                    $display("%0t: out_char expected %h actual %h",
                             $time, exp_res.out_char, result.out_char);
                    errors++;
                end
                if (result.char_valid !== exp_res.char_valid)
                begin
                    $display("%0t: char_valid expected %b actual %b",
                             $time, exp_res.char_valid, result.char_valid);
                    errors++;
                end
                if (result.last_char !== exp_res.last_char)
                begin
                    $display("%0t: last_char expected %b actual %b",
                             $time, exp_res.last_char, result.last_char);
                    errors++;
                end
                if (result.total_count !== exp_res.total_count)
                begin
                    $display("%0t: total_count expected %0d actual %0d",
                             $time, exp_res.total_count, result.total_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_chars.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_reqs.size() > 0 || start || expected_chars.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d requests (%0d directed): sdec %0d, udec %0d, lhex %0d, uhex %0d.",
                 reqs_sent, directed_count, conv_seen[CONV_SDEC], conv_seen[CONV_UDEC],
                 conv_seen[CONV_LHEX], conv_seen[CONV_UHEX]);
        $display("Checked %0d result strobes, %0d of them empty fields; %0d mismatches.",
                 chars_checked, empty_fields, errors);
        if (errors == 0 && expected_chars.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
